FILE: design/uart_line_transceiver_assert.svh
// Assertion macros shared by the transceiver modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef UART_LINE_TRANSCEIVER_ASSERT_SVH
`define UART_LINE_TRANSCEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when a holds, c must hold.
`define ULT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ult assertion failed");
// Next-cycle implication: when a holds, c must hold in the following cycle.
`define ULT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ult assertion failed");
`else
`define ULT_ASSERT_IMP(lbl, a, c)
`define ULT_ASSERT_NXT(lbl, a, c)
`endif

`endif

FILE: design/ult_pkg.sv
package ult_pkg;

  localparam int PERIOD_WIDTH = 24;
  localparam int CNT_WIDTH    = 26;
  localparam int EDGE_WIDTH   = 25;
  localparam logic [EDGE_WIDTH-1:0] EDGE_MAX = {EDGE_WIDTH{1'b1}};

  localparam logic [PERIOD_WIDTH-1:0] RST_BIT_PERIOD = PERIOD_WIDTH'(25);

  localparam logic [2:0] REG_BIT_PERIOD    = 3'd0;
  localparam logic [2:0] REG_DATA_BITS     = 3'd1;
  localparam logic [2:0] REG_STOP_BITS     = 3'd2;
  localparam logic [2:0] REG_PARITY_ENABLE = 3'd3;
  localparam logic [2:0] REG_PARITY_FIXED  = 3'd4;
  localparam logic [2:0] REG_PARITY_SENSE  = 3'd5;

  typedef struct packed {
    logic       line_in;
    logic       send_valid;
    logic [7:0] send_byte;
  } in_word_t;

  typedef struct packed {
    logic       line_out;
    logic       recv_valid;
    logic [7:0] recv_byte;
    logic       send_taken;
  } out_word_t;

  // Effective framing settings, already saturated into their legal ranges.
  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] period;
    logic [3:0]              data_bits;
    logic                    parity_en;
    logic                    parity_fixed;
    logic                    parity_sense;
    logic [3:0]              total;
  } frame_cfg_t;

endpackage

FILE: design/ult_rx.sv
module ult_rx
  import ult_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  frame_cfg_t cfg,
  input  logic       line,
  output logic       recv_valid,
  output logic [7:0] recv_byte
);

`include "uart_line_transceiver_assert.svh"

  logic                  rx_active_r, rx_active_nxt;
  logic [CNT_WIDTH-1:0]  rx_countdown_r, rx_countdown_nxt;
  logic [3:0]            rx_bits_taken_r, rx_bits_taken_nxt;
  logic [10:0]           rx_shifter_r, rx_shifter_nxt;
  logic                  prev_line_r;
  logic [EDGE_WIDTH-1:0] since_edge_r, since_edge_nxt;

  logic [CNT_WIDTH-1:0]  start_sum;
  logic [CNT_WIDTH-1:0]  since_ext;
  logic [CNT_WIDTH-1:0]  reload;
  logic [10:0]           aligned;

  always_comb begin
    if (!line && prev_line_r) begin
      since_edge_nxt = '0;
    end else if (since_edge_r != EDGE_MAX) begin
      since_edge_nxt = since_edge_r + 1'b1;
    end else begin
      since_edge_nxt = since_edge_r;
    end

    // One and a half bit times from the falling edge, less time already low.
    start_sum = CNT_WIDTH'(cfg.period) + CNT_WIDTH'(cfg.period[PERIOD_WIDTH-1:1]);
    since_ext = CNT_WIDTH'(since_edge_nxt);
    reload    = CNT_WIDTH'(cfg.period) - 1'b1;
    aligned   = rx_shifter_r >> (4'd11 - cfg.total);

    rx_active_nxt     = rx_active_r;
    rx_countdown_nxt  = rx_countdown_r;
    rx_bits_taken_nxt = rx_bits_taken_r;
    rx_shifter_nxt    = rx_shifter_r;
    recv_valid        = 1'b0;
    recv_byte         = '0;

    if (!rx_active_r) begin
      if (!line) begin
        rx_active_nxt     = 1'b1;
        rx_countdown_nxt  = (start_sum > since_ext) ? (start_sum - 1'b1 - since_ext) : '0;
        rx_bits_taken_nxt = '0;
        rx_shifter_nxt    = '0;
      end
    end else if (rx_countdown_r == '0) begin
      if (rx_bits_taken_r >= cfg.total) begin
        rx_active_nxt = 1'b0;
        recv_valid    = 1'b1;
        recv_byte     = aligned[7:0];
      end else begin
        rx_bits_taken_nxt = rx_bits_taken_r + 1'b1;
        rx_shifter_nxt    = {line, rx_shifter_r[10:1]};
      end
      rx_countdown_nxt = reload;
    end else begin
      rx_countdown_nxt = rx_countdown_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_active_r     <= 1'b0;
      rx_countdown_r  <= '0;
      rx_bits_taken_r <= '0;
      rx_shifter_r    <= '0;
      prev_line_r     <= 1'b1;
      since_edge_r    <= '0;
    end else if (adv) begin
      rx_active_r     <= rx_active_nxt;
      rx_countdown_r  <= rx_countdown_nxt;
      rx_bits_taken_r <= rx_bits_taken_nxt;
      rx_shifter_r    <= rx_shifter_nxt;
      prev_line_r     <= line;
      since_edge_r    <= since_edge_nxt;
    end
  end

  `ULT_ASSERT_IMP(a_rx_bits_bound, rx_active_r, rx_bits_taken_r <= 4'd11)

endmodule

FILE: design/ult_tx.sv
module ult_tx
  import ult_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  frame_cfg_t cfg,
  input  logic       offer,
  input  logic [7:0] byte_in,
  output logic       line_out,
  output logic       taken
);

`include "uart_line_transceiver_assert.svh"

  logic                    tx_active_r, tx_active_nxt;
  logic [PERIOD_WIDTH-1:0] tx_countdown_r, tx_countdown_nxt;
  logic [11:0]             tx_shifter_r, tx_shifter_nxt;
  logic [3:0]              tx_bits_left_r, tx_bits_left_nxt;

  logic [11:0] frame;
  logic [11:0] shifted;
  logic [3:0]  left_dec;
  logic [7:0]  data_masked;
  logic        par;

  // Frame bits: start at bit 0, data from bit 1, then parity when enabled, then idle ones.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_masked[i] = byte_in[i] & (4'(i) < cfg.data_bits);
    end
    par = cfg.parity_fixed ? cfg.parity_sense : ((^data_masked) ^ cfg.parity_sense);
    for (int i = 0; i < 12; i++) begin
      if (i == 0) begin
        frame[i] = 1'b0;
      end else if (4'(i) <= cfg.data_bits) begin
        frame[i] = data_masked[i-1];
      end else if (4'(i) == cfg.data_bits + 1'b1 && cfg.parity_en) begin
        frame[i] = par;
      end else begin
        frame[i] = 1'b1;
      end
    end
  end

  always_comb begin
    shifted  = {1'b1, tx_shifter_r[11:1]};
    left_dec = (tx_bits_left_r != '0) ? tx_bits_left_r - 1'b1 : tx_bits_left_r;

    tx_active_nxt    = tx_active_r;
    tx_countdown_nxt = tx_countdown_r;
    tx_shifter_nxt   = tx_shifter_r;
    tx_bits_left_nxt = tx_bits_left_r;
    line_out         = 1'b1;
    taken            = 1'b0;

    if (!tx_active_r) begin
      if (offer) begin
        tx_shifter_nxt   = frame;
        tx_bits_left_nxt = cfg.total + 1'b1;
        tx_active_nxt    = 1'b1;
        tx_countdown_nxt = cfg.period - 1'b1;
        taken            = 1'b1;
        line_out         = 1'b0;
      end
    end else if (tx_countdown_r == '0) begin
      tx_shifter_nxt   = shifted;
      tx_bits_left_nxt = left_dec;
      if (left_dec == '0) begin
        tx_active_nxt = 1'b0;
      end else begin
        tx_countdown_nxt = cfg.period - 1'b1;
      end
      line_out = shifted[0];
    end else begin
      tx_countdown_nxt = tx_countdown_r - 1'b1;
      line_out         = tx_shifter_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_active_r    <= 1'b0;
      tx_countdown_r <= '0;
      tx_shifter_r   <= '1;
      tx_bits_left_r <= '0;
    end else if (adv) begin
      tx_active_r    <= tx_active_nxt;
      tx_countdown_r <= tx_countdown_nxt;
      tx_shifter_r   <= tx_shifter_nxt;
      tx_bits_left_r <= tx_bits_left_nxt;
    end
  end

  `ULT_ASSERT_IMP(a_tx_bits_live, tx_active_r, tx_bits_left_r != 4'd0)
  `ULT_ASSERT_IMP(a_tx_bits_bound, tx_active_r, tx_bits_left_r <= 4'd12)

endmodule

FILE: design/uart_line_transceiver.sv
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; each word is one tick of the serial line.
// The single result register sets the rate; input stalls only while it is held.
// Reset (rst_n low, synchronous) restores default framing: 25 ticks per bit,
// 8 data bits, 1 stop bit, no parity; both line engines go idle.
module uart_line_transceiver
  import ult_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "uart_line_transceiver_assert.svh"

  // Configuration registers, written through the APB-style port. Each register
  // lives at byte address 4*index; the low two address bits are ignored.
  logic [PERIOD_WIDTH-1:0] bit_period_r;
  logic [3:0]              data_bits_r;
  logic [1:0]              stop_bits_r;
  logic                    parity_enable_r;
  logic                    parity_fixed_r;
  logic                    parity_sense_r;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r    <= RST_BIT_PERIOD;
      data_bits_r     <= 4'd8;
      stop_bits_r     <= 2'd1;
      parity_enable_r <= 1'b0;
      parity_fixed_r  <= 1'b0;
      parity_sense_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BIT_PERIOD:    bit_period_r    <= pwdata[PERIOD_WIDTH-1:0];
        REG_DATA_BITS:     data_bits_r     <= pwdata[3:0];
        REG_STOP_BITS:     stop_bits_r     <= pwdata[1:0];
        REG_PARITY_ENABLE: parity_enable_r <= pwdata[0];
        REG_PARITY_FIXED:  parity_fixed_r  <= pwdata[0];
        REG_PARITY_SENSE:  parity_sense_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BIT_PERIOD:    prdata = 32'(bit_period_r);
      REG_DATA_BITS:     prdata = 32'(data_bits_r);
      REG_STOP_BITS:     prdata = 32'(stop_bits_r);
      REG_PARITY_ENABLE: prdata = 32'(parity_enable_r);
      REG_PARITY_FIXED:  prdata = 32'(parity_fixed_r);
      REG_PARITY_SENSE:  prdata = 32'(parity_sense_r);
      default:           prdata = '0;
    endcase
  end

  // Effective framing. A zero bit period behaves as one tick, the data count
  // saturates into five to eight and the stop count into one to two.
  frame_cfg_t cfg;
  logic [1:0] stop_eff;

  always_comb begin
    cfg.period = (bit_period_r == '0) ? PERIOD_WIDTH'(1) : bit_period_r;
    if (data_bits_r < 4'd5) begin
      cfg.data_bits = 4'd5;
    end else if (data_bits_r > 4'd8) begin
      cfg.data_bits = 4'd8;
    end else begin
      cfg.data_bits = data_bits_r;
    end
    if (stop_bits_r == 2'd0) begin
      stop_eff = 2'd1;
    end else if (stop_bits_r == 2'd3) begin
      stop_eff = 2'd2;
    end else begin
      stop_eff = stop_bits_r;
    end
    cfg.parity_en    = parity_enable_r;
    cfg.parity_fixed = parity_fixed_r;
    cfg.parity_sense = parity_sense_r;
    cfg.total        = cfg.data_bits + 4'(parity_enable_r) + 4'(stop_eff);
  end

  // Handshake. A word is accepted whenever the result register is empty or is
  // being drained this cycle, so ticks flow one per cycle without a bubble.
  // Both engines advance their state only on an accepted word.
  logic      acc;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  ult_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (acc),
    .cfg        (cfg),
    .line       (in_data.line_in),
    .recv_valid (out_data_nxt.recv_valid),
    .recv_byte  (out_data_nxt.recv_byte)
  );

  ult_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (acc),
    .cfg      (cfg),
    .offer    (in_data.send_valid),
    .byte_in  (in_data.send_byte),
    .line_out (out_data_nxt.line_out),
    .taken    (out_data_nxt.send_taken)
  );

  assign out_valid_nxt = acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload needs no reset; it loads on every accepted word.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ULT_ASSERT_NXT(a_accept_gives_word, in_valid && !in_stall, out_valid)
  `ULT_ASSERT_IMP(a_idle_byte_zero, out_valid && !out_data.recv_valid, out_data.recv_byte == 8'd0)
  `ULT_ASSERT_IMP(a_taken_starts_low, out_valid && out_data.send_taken, !out_data.line_out)

endmodule
